FILE: hw/rtl/link_frame_receiver_assert.svh
// Assertion macros for the link frame receiver.
// Included by the files that assert; needs no other file.
`ifndef LINK_FRAME_RECEIVER_ASSERT_SVH
`define LINK_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Holds in the same cycle whenever the condition holds.
`define LFR_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("link frame receiver: assertion failed");

// Holds in the cycle after the condition holds.
`define LFR_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("link frame receiver: assertion failed");

`else

`define LFR_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define LFR_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

FILE: hw/rtl/lfr_pkg.sv
// Package for the link frame receiver: widths, protocol bytes, reply codes
// and the result record. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 9;
   localparam int DEFAULT_MAX_PAYLOAD = 256;

   localparam logic [BYTE_W-1:0] FLAG_BYTE     = 8'h7E;
   localparam logic [BYTE_W-1:0] ADDR_SENDER   = 8'h03;
   localparam logic [BYTE_W-1:0] ADDR_RECEIVER = 8'h01;
   localparam logic [BYTE_W-1:0] CTL_SET       = 8'h03;
   localparam logic [BYTE_W-1:0] CTL_UA        = 8'h07;
   localparam logic [BYTE_W-1:0] CTL_I0        = 8'h00;
   localparam logic [BYTE_W-1:0] CTL_I1        = 8'h40;
   localparam logic [BYTE_W-1:0] CTL_RR0       = 8'h05;
   localparam logic [BYTE_W-1:0] CTL_RR1       = 8'h85;
   localparam logic [BYTE_W-1:0] CTL_REJ0      = 8'h01;
   localparam logic [BYTE_W-1:0] CTL_REJ1      = 8'h81;

   typedef enum logic [1:0] {
      REPLY_NONE = 2'd0,
      REPLY_UA   = 2'd1,
      REPLY_RR   = 2'd2,
      REPLY_REJ  = 2'd3
   } reply_kind_type;

   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_end;
      reply_kind_type    reply_kind;
      logic [BYTE_W-1:0] reply_control;
      logic [BYTE_W-1:0] reply_check;
      logic [LEN_W-1:0]  payload_length;
   } lfr_result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lfr_channels.sv
// Valid/ready channel interfaces for received bytes and per-byte results.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfr_req_if import lfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              sequence_bit;

   modport source (output valid, output rx_byte, output sequence_bit, input ready);
   modport sink (input valid, input rx_byte, input sequence_bit, output ready);
endinterface

interface lfr_rsp_if import lfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              payload_valid;
   logic [BYTE_W-1:0] payload_byte;
   logic              frame_end;
   logic [1:0]        reply_kind;
   logic [BYTE_W-1:0] reply_control;
   logic [BYTE_W-1:0] reply_check;
   logic [LEN_W-1:0]  payload_length;

   modport source (output valid, output payload_valid, output payload_byte,
                   output frame_end, output reply_kind, output reply_control,
                   output reply_check, output payload_length, input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input frame_end, input reply_kind, input reply_control,
                 input reply_check, input payload_length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lfr_frame_fsm.sv
// Frame parser: phase state machine, payload holding byte, running XOR and
// byte count. Produces the result for the current byte. Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfr_frame_fsm import lfr_pkg::*; #(
   parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              sequence_bit,
   output lfr_result_type    result
);

   localparam int CountW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_FLAG,
      PH_ADDR,
      PH_CTRL,
      PH_BODY
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              frame_is_set_ff, frame_is_set_in;
   logic [BYTE_W-1:0] control_seen_ff, control_seen_in;
   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0] running_xor_ff, running_xor_in;
   logic [CountW-1:0] byte_count_ff, byte_count_in;
   logic              overflowed_ff, overflowed_in;

   logic                    clear_body;
   logic                    frame_ok;
   logic [CountW+LEN_W-1:0] count_wide;

   assign count_wide = {{LEN_W{1'b0}}, byte_count_ff};

   always_comb begin
      phase_in        = phase_ff;
      frame_is_set_in = frame_is_set_ff;
      control_seen_in = control_seen_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      running_xor_in  = running_xor_ff;
      byte_count_in   = byte_count_ff;
      overflowed_in   = overflowed_ff;
      clear_body      = 1'b0;
      frame_ok        = 1'b0;
      result          = '0;

      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == FLAG_BYTE) begin
               phase_in   = PH_FLAG;
               clear_body = 1'b1;
            end
         end
         PH_FLAG: begin
            phase_in = (rx_byte == ADDR_SENDER) ? PH_ADDR : PH_HUNT;
         end
         PH_ADDR: begin
            if (rx_byte == CTL_SET || rx_byte == CTL_I0 || rx_byte == CTL_I1) begin
               control_seen_in = rx_byte;
               frame_is_set_in = (rx_byte == CTL_SET);
               phase_in        = PH_CTRL;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_CTRL: begin
            if (rx_byte == (ADDR_SENDER ^ control_seen_ff)) begin
               phase_in   = PH_BODY;
               clear_body = 1'b1;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_BODY: begin
            if (frame_is_set_ff) begin
               if (rx_byte == FLAG_BYTE) begin
                  result.frame_end     = 1'b1;
                  result.reply_kind    = REPLY_UA;
                  result.reply_control = CTL_UA;
               end
               phase_in = PH_HUNT;
            end else if (rx_byte == FLAG_BYTE) begin
               frame_ok = held_valid_ff && (byte_count_ff != '0) && !overflowed_ff &&
                          (held_byte_ff == running_xor_ff);
               result.frame_end      = 1'b1;
               result.payload_length = count_wide[LEN_W-1:0];
               if (frame_ok) begin
                  result.reply_kind    = REPLY_RR;
                  result.reply_control = sequence_bit ? CTL_RR1 : CTL_RR0;
               end else begin
                  result.reply_kind    = REPLY_REJ;
                  result.reply_control = sequence_bit ? CTL_REJ1 : CTL_REJ0;
               end
               phase_in   = PH_HUNT;
               clear_body = 1'b1;
            end else begin
               if (held_valid_ff) begin
                  if (byte_count_ff < MaxCount) begin
                     result.payload_valid = 1'b1;
                     result.payload_byte  = held_byte_ff;
                     running_xor_in       = running_xor_ff ^ held_byte_ff;
                     byte_count_in        = byte_count_ff + 1'b1;
                  end else begin
                     overflowed_in = 1'b1;
                  end
               end
               held_byte_in  = rx_byte;
               held_valid_in = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase

      if (clear_body) begin
         held_byte_in   = '0;
         held_valid_in  = 1'b0;
         running_xor_in = '0;
         byte_count_in  = '0;
         overflowed_in  = 1'b0;
      end

      if (result.reply_kind != REPLY_NONE) begin
         result.reply_check = ADDR_RECEIVER ^ result.reply_control;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         frame_is_set_ff <= 1'b0;
         control_seen_ff <= '0;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         running_xor_ff  <= '0;
         byte_count_ff   <= '0;
         overflowed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         frame_is_set_ff <= frame_is_set_in;
         control_seen_ff <= control_seen_in;
         held_byte_ff    <= held_byte_in;
         held_valid_ff   <= held_valid_in;
         running_xor_ff  <= running_xor_in;
         byte_count_ff   <= byte_count_in;
         overflowed_ff   <= overflowed_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/link_frame_receiver.sv
// Link frame receiver top level: frame parser plus a two-entry result stage.
// Depends on lfr_pkg, lfr_channels, lfr_frame_fsm and the assertion header.
//
// The receiver takes one byte per clock cycle while its spare result entry is
// free and returns exactly one result item per byte, in order. The result of
// an accepted byte is registered in the output register, or in the spare entry
// while the output waits, so req_chan.ready depends only on that entry being
// free. The frame state update loops back through the parser registers.
// MAX_PAYLOAD sets the payload byte limit per frame; payload_length reports
// the delivered count in its low nine bits.
`timescale 1ns / 1ps
`default_nettype none
`include "link_frame_receiver_assert.svh"

module link_frame_receiver import lfr_pkg::*; #(
   parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic      clock,
   input  logic      reset,
   lfr_req_if.sink   req_chan,
   lfr_rsp_if.source rsp_chan
);

   logic           accept;
   logic           out_free;
   lfr_result_type fsm_result;

   logic           rsp_valid_ff, rsp_valid_in;
   lfr_result_type rsp_data_ff, rsp_data_in;
   logic           skid_valid_ff, skid_valid_in;
   lfr_result_type skid_data_ff, skid_data_in;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   lfr_frame_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_frame_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .rx_byte      (req_chan.rx_byte),
      .sequence_bit (req_chan.sequence_bit),
      .result       (fsm_result)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = fsm_result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = fsm_result;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.payload_valid  = rsp_data_ff.payload_valid;
   assign rsp_chan.payload_byte   = rsp_data_ff.payload_byte;
   assign rsp_chan.frame_end      = rsp_data_ff.frame_end;
   assign rsp_chan.reply_kind     = rsp_data_ff.reply_kind;
   assign rsp_chan.reply_control  = rsp_data_ff.reply_control;
   assign rsp_chan.reply_check    = rsp_data_ff.reply_check;
   assign rsp_chan.payload_length = rsp_data_ff.payload_length;

   // The spare entry is only ever occupied behind a waiting output item.
   `LFR_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `LFR_ASSERT_NEXT(a_stall_fills_skid, clock, reset, accept && !out_free, skid_valid_ff)
   `LFR_ASSERT_IMPLIES(a_no_reply_fields, clock, reset, rsp_valid_ff && rsp_data_ff.reply_kind == REPLY_NONE, rsp_data_ff.reply_control == '0 && rsp_data_ff.reply_check == '0 && !rsp_data_ff.frame_end)
   `LFR_ASSERT_IMPLIES(a_payload_not_at_end, clock, reset, rsp_valid_ff, !(rsp_data_ff.payload_valid && rsp_data_ff.frame_end))

endmodule

`default_nettype wire
